// ===== hdl/fpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants, types and the helper function of the fan speed and
// tachometer monitor.
// ----------------------------------------------------------------------------
package fpt_pkg;

	localparam int TICKS_PER_MS      = 1000;
	localparam int PULSE_COUNT_WIDTH = 24;

	localparam int PRE_W      = $clog2(TICKS_PER_MS + 1);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_W      = PULSE_COUNT_WIDTH + 16;
	localparam int DEN_W      = 20;
	localparam int CNT_W      = $clog2(NUM_W);

	localparam logic [15:0] RPM_MINUTE_MS = 16'd60000;
	localparam logic [15:0] GAP_SAT       = 16'hFFFF;
	localparam logic [6:0]  PCT_FULL      = 7'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_PPR     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_STALL   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = CFG_IDX_W'(3);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIV  = 6'b001000,
		S_SAT  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic mul;
		logic div_step;
		logic sat;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_last;
	} sts_t;

	// speed*255/100 through a reciprocal multiply, exact for speed up to 100
	function automatic logic [7:0] duty_of(input logic [6:0] speed);
		logic [14:0] p;
		logic [27:0] m;
		p = 15'(speed) * 15'd255;
		m = 28'(p) * 28'd5243;
		return m[26:19];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_ctrl
// Controller: sequences capture, update, rpm division and output load,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module fpt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire fpt_pkg::sts_t sts,
	output fpt_pkg::cmd_t      cmd
);

	fpt_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fpt_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = fpt_pkg::S_EXEC;
				end
			end
			fpt_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.close ? fpt_pkg::S_MUL : fpt_pkg::S_DONE;
			end
			fpt_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = fpt_pkg::S_DIV;
			end
			fpt_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = fpt_pkg::S_SAT;
				end
			end
			fpt_pkg::S_SAT: begin
				cmd.sat = 1'b1;
				state_d = fpt_pkg::S_DONE;
			end
			fpt_pkg::S_DONE: begin
				// wait for the output register to free up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = fpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fpt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != fpt_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/fpt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_datapath
// Datapath: config registers, speed and tach counters, rpm multiply and
// restoring divider, result register.
// ----------------------------------------------------------------------------
module fpt_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fpt_pkg::cmd_t                  cmd,
	output fpt_pkg::sts_t                       sts,
	input  wire logic                           cfg_we,
	input  wire logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           func,
	input  wire logic                           tach_fall,
	input  wire logic [7:0]                     speed_in,
	output logic [7:0]                          duty,
	output logic [6:0]                          speed_now,
	output logic [15:0]                         rpm,
	output logic                                stalled,
	output logic                                rpm_updated
);

	localparam logic [fpt_pkg::PULSE_COUNT_WIDTH-1:0] PULSE_MAX = '1;

	// configuration
	logic [3:0]  ppr_q;
	logic [15:0] window_q;
	logic [15:0] stall_rpm_q;
	logic [15:0] min_gap_q;

	// captured beat
	logic       func_q;
	logic       fall_q;
	logic [7:0] speed_in_q;

	// block state
	logic [6:0]                          speed_q;
	logic [15:0]                         rpm_q;
	logic [fpt_pkg::PULSE_COUNT_WIDTH-1:0] pulse_q;
	logic [15:0]                         gap_q;
	logic [fpt_pkg::PRE_W-1:0]           pre_q;
	logic [15:0]                         ms_q;
	logic                                upd_q;

	// divider
	logic [fpt_pkg::NUM_W-1:0] quo_q;
	logic [fpt_pkg::DEN_W-1:0] den_q;
	logic [fpt_pkg::DEN_W-1:0] rem_q;
	logic [fpt_pkg::CNT_W-1:0] cnt_q;

	// result register
	logic [7:0]  duty_q;
	logic [6:0]  speed_now_q;
	logic [15:0] rpm_out_q;
	logic        stalled_q;
	logic        rpm_updated_q;

	// tick update
	logic [15:0]                           gap_inc;
	logic                                  edge_ok;
	logic [fpt_pkg::PULSE_COUNT_WIDTH-1:0] pulse_next;
	logic [15:0]                           gap_next;
	logic [fpt_pkg::PRE_W-1:0]             pre_inc;
	logic                                  ms_tick;
	logic [15:0]                           ms_next;
	logic                                  close_c;
	logic [6:0]                            speed_clamp;

	// division step
	logic [fpt_pkg::DEN_W:0] trial;
	logic                    fits;
	logic [3:0]              ppr_eff;
	logic [15:0]             ms_eff;

	always_comb begin
		gap_inc    = (gap_q != fpt_pkg::GAP_SAT) ? gap_q + 16'd1 : gap_q;
		edge_ok    = fall_q && (gap_inc == fpt_pkg::GAP_SAT || gap_inc > min_gap_q);
		pulse_next = (edge_ok && pulse_q != PULSE_MAX) ?
			pulse_q + fpt_pkg::PULSE_COUNT_WIDTH'(1) : pulse_q;
		gap_next   = edge_ok ? 16'd0 : gap_inc;
		pre_inc    = pre_q + fpt_pkg::PRE_W'(1);
		ms_tick    = (pre_inc >= fpt_pkg::PRE_W'(fpt_pkg::TICKS_PER_MS));
		ms_next    = (ms_tick && ms_q != 16'hFFFF) ? ms_q + 16'd1 : ms_q;
		close_c    = ms_tick && (ms_next >= window_q);
		speed_clamp = (speed_in_q > 8'(fpt_pkg::PCT_FULL)) ?
			fpt_pkg::PCT_FULL : speed_in_q[6:0];
	end

	assign ppr_eff = (ppr_q != 4'd0) ? ppr_q : 4'd1;
	assign ms_eff  = (ms_q != 16'd0) ? ms_q : 16'd1;

	assign trial = {rem_q, quo_q[fpt_pkg::NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	assign sts.close    = !func_q && close_c;
	assign sts.div_last = (cnt_q == fpt_pkg::CNT_W'(fpt_pkg::NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q       <= 4'd2;
			window_q    <= 16'd1000;
			stall_rpm_q <= 16'd300;
			min_gap_q   <= 16'd9000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpt_pkg::CFG_PPR:     ppr_q       <= cfg_data[3:0];
				fpt_pkg::CFG_WINDOW:  window_q    <= cfg_data[15:0];
				fpt_pkg::CFG_STALL:   stall_rpm_q <= cfg_data[15:0];
				fpt_pkg::CFG_MIN_GAP: min_gap_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			rpm_q   <= '0;
			pulse_q <= '0;
			gap_q   <= fpt_pkg::GAP_SAT;
			pre_q   <= '0;
			ms_q    <= '0;
			upd_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (func_q) begin
					speed_q <= speed_clamp;
					upd_q   <= 1'b0;
				end else begin
					pulse_q <= pulse_next;
					gap_q   <= gap_next;
					pre_q   <= ms_tick ? '0 : pre_inc;
					ms_q    <= ms_next;
					upd_q   <= close_c;
				end
			end
			// window closed: counters clear once their values are taken
			if (cmd.mul) begin
				pulse_q <= '0;
				ms_q    <= '0;
			end
			if (cmd.sat) begin
				rpm_q <= (|quo_q[fpt_pkg::NUM_W-1:16]) ? 16'hFFFF : quo_q[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			fall_q     <= tach_fall;
			speed_in_q <= speed_in;
		end
		if (cmd.mul) begin
			quo_q <= fpt_pkg::NUM_W'(pulse_q) * fpt_pkg::NUM_W'(fpt_pkg::RPM_MINUTE_MS);
			den_q <= fpt_pkg::DEN_W'(ppr_eff) * fpt_pkg::DEN_W'(ms_eff);
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			// one quotient bit per cycle, msb first
			quo_q <= {quo_q[fpt_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? fpt_pkg::DEN_W'(trial - {1'b0, den_q}) :
				trial[fpt_pkg::DEN_W-1:0];
			cnt_q <= cnt_q + fpt_pkg::CNT_W'(1);
		end
		if (cmd.load_out) begin
			duty_q        <= fpt_pkg::duty_of(speed_q);
			speed_now_q   <= speed_q;
			rpm_out_q     <= rpm_q;
			stalled_q     <= (speed_q != 7'd0) && (rpm_q < stall_rpm_q);
			rpm_updated_q <= upd_q;
		end
	end

	assign duty        = duty_q;
	assign speed_now   = speed_now_q;
	assign rpm         = rpm_out_q;
	assign stalled     = stalled_q;
	assign rpm_updated = rpm_updated_q;

endmodule
`default_nettype wire

// ===== hdl/fan_pwm_tach_monitor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fan_pwm_tach_monitor
// Fan speed setting and tachometer rpm measurement over a millisecond window.
//
// channel   handshake             payload
// input     in_valid / in_stall   func, tach_fall, speed_in
// output    out_valid / out_stall duty, speed_now, rpm, stalled, rpm_updated
// config    cfg_we                cfg_index, cfg_data
//
// a set-speed beat or a tick that closes no window passes the update state
// and then the done state into the output register; a tick that closes a
// window passes update, multiply, the one-bit-per-cycle restoring divider
// (40 steps) and saturate before the done state. one beat is in work at a
// time; in_stall is high from acceptance until the result is moved into the
// output register, which holds it under out_stall. reset leaves the pulse,
// millisecond and prescale counters cleared, the gap counter saturated and
// the config registers at their defaults.
// ----------------------------------------------------------------------------
module fan_pwm_tach_monitor (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic                           tach_fall,
	input  wire logic [7:0]                     speed_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          duty,
	output logic [6:0]                          speed_now,
	output logic [15:0]                         rpm,
	output logic                                stalled,
	output logic                                rpm_updated
);

	fpt_pkg::cmd_t cmd;
	fpt_pkg::sts_t sts;

	fpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.tach_fall   (tach_fall),
		.speed_in    (speed_in),
		.duty        (duty),
		.speed_now   (speed_now),
		.rpm         (rpm),
		.stalled     (stalled),
		.rpm_updated (rpm_updated)
	);

endmodule
`default_nettype wire
